>>> rtl/ffba_pkg.sv
// ffba_pkg: shared types and constants for the first-fit block bitmap allocator.
// Beat structs, controller state encoding and default geometry.
// No dependencies.
package ffba_pkg;

	// default geometry; BLOCK_BYTES must be a power of two
	localparam int BLOCK_BYTES_DEF = 65536;
	localparam int HEAP_BLOCKS_DEF = 64;
	localparam int MAX_HEAPS_DEF   = 4;

	localparam int SIZE_W = 32;
	localparam int OFF_W  = 22;
	localparam int HEAP_W = 2;
	localparam int CFG_W  = 3;

	localparam logic [CFG_W-1:0] CFG_HEAPS_RST = 3'd1;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_NO_SPACE = 1'b1;

	typedef struct packed {
		logic              func;
		logic [SIZE_W-1:0] size_bytes;
		logic [HEAP_W-1:0] heap_index;
		logic [OFF_W-1:0]  byte_offset;
	} req_t;

	typedef struct packed {
		logic              status;
		logic [HEAP_W-1:0] granted_heap;
		logic [OFF_W-1:0]  granted_offset;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_CHK,
		ST_SEL,
		ST_RES
	} state_t;

endpackage

>>> rtl/ffba_map_mem.sv
// ffba_map_mem: used-block bitmap store, one word per heap.
// Synchronous read through a registered read port; per-word valid bits make unwritten words read as free.
// Depends on nothing.
module ffba_map_mem #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rd_q;
	logic             rvld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rvld_q <= (32'(raddr) < DEPTH) ? vld_q[raddr] : 1'b0;
		end
	end

	// never-written word reads as all free
	assign rdata = rvld_q ? rd_q : '0;

endmodule

>>> rtl/ffba_run_search.sv
// ffba_run_search: marks every block that starts a run of need free blocks.
// Doubling scheme: runs of 2^k are built by shift-and, then combined per bit of need.
// Depends on nothing.
module ffba_run_search #(
	parameter int WIDTH  = 64,
	parameter int NEED_W = 7
) (
	input  logic [WIDTH-1:0]  used,
	input  logic [NEED_W-1:0] need,
	output logic [WIDTH-1:0]  starts
);

	logic [WIDTH-1:0]  runs;
	logic [WIDTH-1:0]  acc;
	logic [NEED_W-1:0] sh;

	// runs holds "run of 2^k free blocks starts here"; sh is the length already covered.
	// Shifting right brings in zeros, so runs never cross the end of the heap.
	always_comb begin
		runs = ~used;
		acc  = '1;
		sh   = '0;
		for (int k = 0; k < NEED_W; k++) begin
			sh = need & NEED_W'((1 << k) - 1);
			if (need[k]) begin
				acc = acc & (runs >> sh);
			end
			runs = runs & (runs >> (1 << k));
		end
		starts = acc;
	end

endmodule

>>> rtl/first_fit_block_bitmap_allocator_top.sv
// first_fit_block_bitmap_allocator_top: first-fit block allocator over a bitmap per heap.
// Uses ffba_pkg, ffba_map_mem and ffba_run_search.
//
// Each heap is a row of HEAP_BLOCKS blocks of BLOCK_BYTES bytes (a power of two), tracked by
// one used bit per block in a small synchronous memory, one word per heap. An allocate beat
// rounds size_bytes up to whole blocks (at least one), then walks heaps 0 .. heaps_in_use-1
// (clamped to MAX_HEAPS) and grabs the lowest run of enough free blocks, answering with heap
// and byte offset, or status 1 when nothing fits. A free beat clears blocks starting at the
// block holding byte_offset, clipped at the heap end, and always answers status 0 with zero
// heap and offset. One request is in flight at a time; every word is a read-modify-write
// through the memory port, so there is no overlap to forward. Free passes the read,
// clear/write and result states; allocate passes read, run search and select/write per heap
// searched, then result; an oversize request or zero heaps goes straight to result. The next
// request is taken in the cycle after the result is registered, even if that result is still
// waiting on rsp_ready. heaps_in_use is written through cfg_we/cfg_wdata; the user must
// write it only while the block is idle, which the block itself does not enforce. After
// reset every block is free and heaps_in_use is 1; no clearing pass is needed.
module first_fit_block_bitmap_allocator_top #(
	parameter int BLOCK_BYTES = ffba_pkg::BLOCK_BYTES_DEF,
	parameter int HEAP_BLOCKS = ffba_pkg::HEAP_BLOCKS_DEF,
	parameter int MAX_HEAPS   = ffba_pkg::MAX_HEAPS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// request channel
	input  logic                       req_valid,
	output logic                       req_ready,
	input  ffba_pkg::req_t             req,
	// response channel
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output ffba_pkg::rsp_t             rsp,
	// heaps_in_use register
	input  logic                       cfg_we,
	input  logic [ffba_pkg::CFG_W-1:0] cfg_wdata
);

	localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
	localparam int NEED_W      = $clog2(HEAP_BLOCKS + 1);
	localparam int IDX_W       = $clog2(HEAP_BLOCKS);
	localparam int HIDX_W      = (MAX_HEAPS > 1) ? $clog2(MAX_HEAPS) : 1;
	localparam int HCNT_W      = $clog2(MAX_HEAPS + 1);
	localparam int BLK_W       = ffba_pkg::SIZE_W + 1;
	localparam int END_W       = BLK_W + 1;
	localparam int OFF_W       = ffba_pkg::OFF_W;

	ffba_pkg::state_t state_q, state_d;

	logic [ffba_pkg::CFG_W-1:0] cfg_heaps_q;

	// request context
	logic                   func_q;
	logic [NEED_W-1:0]      need_q;
	logic [HEAP_BLOCKS-1:0] clr_q;
	logic                   fheap_ok_q;
	logic [HIDX_W-1:0]      h_q;
	logic [HCNT_W-1:0]      cnt_q;

	// search stage
	logic [HEAP_BLOCKS-1:0] starts_s1;
	logic [HEAP_BLOCKS-1:0] word_s1;

	ffba_pkg::rsp_t res_q;
	ffba_pkg::rsp_t out_q;
	logic           out_valid_q;

	// request decode
	logic [BLK_W-1:0]       blocks;
	logic [BLK_W-1:0]       blocks_eff;
	logic                   too_big;
	logic [NEED_W-1:0]      need_d;
	logic [OFF_W-1:0]       start_blk;
	logic [END_W-1:0]       end_blk;
	logic [HEAP_BLOCKS-1:0] clr_d;
	logic                   fheap_ok;
	logic [HIDX_W+1:0]      fheap_ext;
	logic [HCNT_W-1:0]      cnt_d;
	logic                   accept;

	// memory and search
	logic [HEAP_BLOCKS-1:0] rword;
	logic [HEAP_BLOCKS-1:0] starts;
	logic                   mem_we;
	logic [HEAP_BLOCKS-1:0] mem_wdata;

	// select
	logic                   found;
	logic [IDX_W-1:0]       p_sel;
	logic [HEAP_BLOCKS-1:0] run_mask;
	logic [OFF_W+IDX_W-1:0] off_ext;
	logic [HIDX_W+1:0]      gh_ext;
	logic                   last_heap;
	logic                   out_load;

	assign accept = req_valid && req_ready;

	// ---- request decode: block count, free range, heap count ----
	always_comb begin
		blocks     = (BLK_W'(req.size_bytes) + BLK_W'(BLOCK_BYTES - 1)) >> BLOCK_SHIFT;
		blocks_eff = (blocks == '0) ? BLK_W'(1) : blocks;
		too_big    = blocks_eff > BLK_W'(HEAP_BLOCKS);
		need_d     = too_big ? '0 : blocks_eff[NEED_W-1:0];
		start_blk  = req.byte_offset >> BLOCK_SHIFT;
		end_blk    = END_W'(start_blk) + END_W'(blocks_eff);
		for (int j = 0; j < HEAP_BLOCKS; j++) begin
			clr_d[j] = (END_W'(j) >= END_W'(start_blk)) && (END_W'(j) < end_blk);
		end
		fheap_ok  = 32'(req.heap_index) < MAX_HEAPS;
		fheap_ext = {{HIDX_W{1'b0}}, req.heap_index};
		cnt_d     = (32'(cfg_heaps_q) >= MAX_HEAPS) ? HCNT_W'(MAX_HEAPS)
		                                            : HCNT_W'(cfg_heaps_q);
	end

	// ---- bitmap store and run search ----
	ffba_map_mem #(
		.WIDTH (HEAP_BLOCKS),
		.DEPTH (MAX_HEAPS)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.raddr  (h_q),
		.rdata  (rword),
		.we     (mem_we),
		.waddr  (h_q),
		.wdata  (mem_wdata)
	);

	ffba_run_search #(
		.WIDTH  (HEAP_BLOCKS),
		.NEED_W (NEED_W)
	) u_search (
		.used   (rword),
		.need   (need_q),
		.starts (starts)
	);

	// ---- select: lowest run start, its mask and byte offset ----
	always_comb begin
		found = |starts_s1;
		p_sel = '0;
		for (int j = HEAP_BLOCKS - 1; j >= 0; j--) begin
			if (starts_s1[j]) begin
				p_sel = IDX_W'(j);
			end
		end
		for (int j = 0; j < HEAP_BLOCKS; j++) begin
			run_mask[j] = (32'(j) >= 32'(p_sel)) && (32'(j) < 32'(p_sel) + 32'(need_q));
		end
		off_ext   = {{OFF_W{1'b0}}, p_sel} << BLOCK_SHIFT;
		gh_ext    = {2'b00, h_q};
		last_heap = (32'(h_q) + 32'd1) >= 32'(cnt_q);
	end

	// ---- controller: next state and outputs ----
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		mem_we    = 1'b0;
		mem_wdata = word_s1 | run_mask;
		out_load  = 1'b0;
		case (state_q)
			ffba_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (req.func == ffba_pkg::FUNC_FREE) begin
						state_d = ffba_pkg::ST_RD;
					end else if (too_big || cnt_d == '0) begin
						state_d = ffba_pkg::ST_RES;
					end else begin
						state_d = ffba_pkg::ST_RD;
					end
				end
			end
			ffba_pkg::ST_RD: begin
				state_d = ffba_pkg::ST_CHK;
			end
			ffba_pkg::ST_CHK: begin
				if (func_q == ffba_pkg::FUNC_FREE) begin
					mem_we    = fheap_ok_q;
					mem_wdata = rword & ~clr_q;
					state_d   = ffba_pkg::ST_RES;
				end else begin
					state_d = ffba_pkg::ST_SEL;
				end
			end
			ffba_pkg::ST_SEL: begin
				if (found) begin
					mem_we  = 1'b1;
					state_d = ffba_pkg::ST_RES;
				end else if (last_heap) begin
					state_d = ffba_pkg::ST_RES;
				end else begin
					state_d = ffba_pkg::ST_RD;
				end
			end
			ffba_pkg::ST_RES: begin
				if (!out_valid_q || rsp_ready) begin
					out_load = 1'b1;
					state_d  = ffba_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ffba_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffba_pkg::ST_IDLE;
			cfg_heaps_q <= ffba_pkg::CFG_HEAPS_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cfg_heaps_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---- datapath registers ----
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q     <= req.func;
			need_q     <= need_d;
			clr_q      <= clr_d;
			fheap_ok_q <= fheap_ok;
			cnt_q      <= cnt_d;
			// free works on the named heap; allocate walks from heap 0
			h_q        <= (req.func == ffba_pkg::FUNC_FREE) ? fheap_ext[HIDX_W-1:0] : '0;
			// default answer: free success, or allocate failure unless a run is found
			res_q.status         <= (req.func == ffba_pkg::FUNC_FREE) ? ffba_pkg::STATUS_OK
			                                                          : ffba_pkg::STATUS_NO_SPACE;
			res_q.granted_heap   <= '0;
			res_q.granted_offset <= '0;
		end
		if (state_q == ffba_pkg::ST_CHK) begin
			starts_s1 <= starts;
			word_s1   <= rword;
		end
		if (state_q == ffba_pkg::ST_SEL) begin
			if (found) begin
				res_q.status         <= ffba_pkg::STATUS_OK;
				res_q.granted_heap   <= gh_ext[1:0];
				res_q.granted_offset <= off_ext[OFF_W-1:0];
			end else if (!last_heap) begin
				h_q <= h_q + HIDX_W'(1);
			end
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

>>> rtl/ffba_checker.sv
// ffba_checker: port-level checks for first_fit_block_bitmap_allocator_top, bound below.
// Depends on ffba_pkg.
module ffba_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input ffba_pkg::rsp_t rsp
);

	// response beat holds until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response beat dropped or changed while stalled");

	// one request at a time: no accept right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in flight");

	// a failed allocate carries no location
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ffba_pkg::STATUS_NO_SPACE |->
			rsp.granted_heap == '0 && rsp.granted_offset == '0)
		else $error("no-space beat carries heap or offset");

	// a fresh response never rises straight after an accept
	a_rsp_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_valid && req_ready))
		else $error("response raised in the cycle after accept");

endmodule

bind first_fit_block_bitmap_allocator_top ffba_checker u_ffba_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
